// ===== design/mfbd_pkg.sv =====
// shared constants and types for the facet distance block
`timescale 1ns / 1ps

package mfbd_pkg;

  // default facet capacity
  localparam int unsigned MAX_FACETS_DEF = 1024;

  // fixed field widths
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned FACET_W = 10;
  localparam int unsigned DIST_W  = 16;
  localparam int unsigned NBR_W   = 11;
  // wide enough to hold the largest facet capacity itself
  localparam int unsigned CNT_W   = 17;

  // edges per triangle
  localparam int unsigned EDGES  = 3;
  localparam int unsigned EDGE_W = 2;
  localparam logic [EDGE_W-1:0] EDGE_LAST = EDGE_W'(EDGES - 1);

  // saturated distance
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // transaction modes
  localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RUN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

  // per-facet record: membership and distance
  typedef struct packed {
    logic              member;
    logic [DIST_W-1:0] dist_val;
  } facet_rec_t;

  // neighbours across the three local edges
  typedef struct packed {
    logic [NBR_W-1:0] nb_c;
    logic [NBR_W-1:0] nb_b;
    logic [NBR_W-1:0] nb_a;
  } nbr_rec_t;

endpackage

// ===== design/mfbd_req_if.sv =====
// request channel interface for the facet distance block
`timescale 1ns / 1ps

interface mfbd_req_if;
  import mfbd_pkg::*;

  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [FACET_W-1:0] facet;
  logic               member;
  logic [DIST_W-1:0]  start_distance;
  logic [NBR_W-1:0]   neighbor_a;
  logic [NBR_W-1:0]   neighbor_b;
  logic [NBR_W-1:0]   neighbor_c;

  modport source (
    output valid, mode, facet, member, start_distance,
           neighbor_a, neighbor_b, neighbor_c,
    input  ready
  );

  modport sink (
    input  valid, mode, facet, member, start_distance,
           neighbor_a, neighbor_b, neighbor_c,
    output ready
  );

endinterface

// ===== design/mfbd_rsp_if.sv =====
// response channel interface for the facet distance block
`timescale 1ns / 1ps

interface mfbd_rsp_if;
  import mfbd_pkg::*;

  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] facet_distance;
  logic              is_member;
  logic              status;

  modport source (
    output valid, facet_distance, is_member, status,
    input  ready
  );

  modport sink (
    input  valid, facet_distance, is_member, status,
    output ready
  );

endinterface

// ===== design/mfbd_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module mfbd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/mesh_facet_bfs_distance.sv =====
// load, bad-index and unused-mode transactions register their result directly at accept
// a read passes through the facet ram read register and S_READ into the reply register; one transaction at a time
// a run scans every facet for seeds, then per dequeued facet passes S_POP, S_CUR and S_FETCH, visits
// each neighbour in S_EDGE and, if present, S_CHECK, and ends when S_POP finds the queue empty; facet ram port bound
// after reset a clearing pass writes every facet entry to empty membership; no request is taken
// control state is cleared by the synchronous active-high reset
`timescale 1ns / 1ps

module mesh_facet_bfs_distance #(
  parameter int unsigned MAX_FACETS = mfbd_pkg::MAX_FACETS_DEF
) (
  input logic        clk,
  input logic        rst,
  mfbd_req_if.sink   req,
  mfbd_rsp_if.source rsp
);
  import mfbd_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_FACETS);
  localparam int unsigned PTR_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] MAX_F     = CNT_W'(MAX_FACETS);
  localparam logic [PTR_W-1:0] PTR_FULL  = PTR_W'(MAX_FACETS);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(MAX_FACETS - 1);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_READ  = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_POP   = 9'b000010000,
    S_CUR   = 9'b000100000,
    S_FETCH = 9'b001000000,
    S_EDGE  = 9'b010000000,
    S_CHECK = 9'b100000000
  } state_t;

  // S_IDLE doubles as the reply wait after a run; a separate flag marks it
  state_t state, state_next;
  logic   reply_pend, reply_pend_next;

  logic [IDX_W-1:0]  clr_addr, clr_addr_next;
  logic [IDX_W-1:0]  scan_addr, scan_addr_next;
  logic [IDX_W-1:0]  scan_prev, scan_prev_next;
  logic              scan_busy, scan_busy_next;
  logic              scan_pend, scan_pend_next;
  logic [PTR_W-1:0]  head, head_next;
  logic [PTR_W-1:0]  tail, tail_next;
  logic [DIST_W-1:0] d, d_next;
  nbr_rec_t          nbrs, nbrs_next;
  logic [EDGE_W-1:0] edge_idx, edge_idx_next;
  logic [IDX_W-1:0]  nb_reg, nb_reg_next;

  logic              rsp_valid, rsp_valid_next;
  logic [DIST_W-1:0] rsp_dist, rsp_dist_next;
  logic              rsp_mem, rsp_mem_next;
  logic              rsp_status, rsp_status_next;

  // ram ports
  logic             fac_wr_en, fac_rd_en;
  logic [IDX_W-1:0] fac_wr_addr, fac_rd_addr;
  facet_rec_t       fac_wr_data, fac_rd_data;
  logic             nbr_wr_en, nbr_rd_en;
  nbr_rec_t         nbr_wr_data, nbr_rd_data;
  logic             q_wr_en, q_rd_en;
  logic [IDX_W-1:0] q_wr_addr, q_rd_addr, q_wr_data, q_rd_data;

  logic             slot_free, req_take, req_in_range, nb_present;
  logic [NBR_W-1:0] nb_sel;

  assign slot_free = !rsp_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && !reply_pend && slot_free;
  assign req_take  = req.valid && req.ready;
  assign req_in_range = {{(CNT_W-FACET_W){1'b0}}, req.facet} < MAX_F;

  assign rsp.valid          = rsp_valid;
  assign rsp.facet_distance = rsp_dist;
  assign rsp.is_member      = rsp_mem;
  assign rsp.status         = rsp_status;

  // neighbour under the current edge
  always_comb begin
    case (edge_idx)
      2'd0:    nb_sel = nbrs.nb_a;
      2'd1:    nb_sel = nbrs.nb_b;
      default: nb_sel = nbrs.nb_c;
    endcase
  end
  assign nb_present = {{(CNT_W-NBR_W){1'b0}}, nb_sel} < MAX_F;

  // sequencer
  always_comb begin
    state_next      = state;
    reply_pend_next = reply_pend;
    clr_addr_next   = clr_addr;
    scan_addr_next  = scan_addr;
    scan_prev_next  = scan_prev;
    scan_busy_next  = scan_busy;
    scan_pend_next  = scan_pend;
    head_next       = head;
    tail_next       = tail;
    d_next          = d;
    nbrs_next       = nbrs;
    edge_idx_next   = edge_idx;
    nb_reg_next     = nb_reg;
    rsp_valid_next  = rsp_valid && !rsp.ready;
    rsp_dist_next   = rsp_dist;
    rsp_mem_next    = rsp_mem;
    rsp_status_next = rsp_status;

    fac_wr_en   = 1'b0;
    fac_wr_addr = '0;
    fac_wr_data = '0;
    fac_rd_en   = 1'b0;
    fac_rd_addr = '0;
    nbr_wr_en   = 1'b0;
    nbr_wr_data = '0;
    nbr_rd_en   = 1'b0;
    q_wr_en     = 1'b0;
    q_wr_addr   = '0;
    q_wr_data   = '0;
    q_rd_en     = 1'b0;
    q_rd_addr   = '0;

    case (state)
      // clear membership one entry per cycle
      S_CLEAR: begin
        fac_wr_en   = 1'b1;
        fac_wr_addr = clr_addr;
        if (clr_addr == IDX_LAST) begin
          state_next = S_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end

      // take a transaction, or finish a run reply
      S_IDLE: begin
        if (reply_pend) begin
          if (slot_free) begin
            rsp_valid_next  = 1'b1;
            rsp_dist_next   = '0;
            rsp_mem_next    = 1'b0;
            rsp_status_next = 1'b0;
            reply_pend_next = 1'b0;
          end
        end else if (req_take) begin
          rsp_dist_next   = '0;
          rsp_mem_next    = 1'b0;
          rsp_status_next = 1'b0;
          case (req.mode)
            MODE_LOAD: begin
              rsp_valid_next  = 1'b1;
              rsp_status_next = !req_in_range;
              fac_wr_en       = req_in_range;
              nbr_wr_en       = req_in_range;
              fac_wr_addr     = IDX_W'(req.facet);
              fac_wr_data     = '{member: req.member, dist_val: req.start_distance};
              nbr_wr_data     = '{nb_c: req.neighbor_c, nb_b: req.neighbor_b,
                                  nb_a: req.neighbor_a};
            end
            MODE_RUN: begin
              head_next      = '0;
              tail_next      = '0;
              scan_addr_next = '0;
              scan_busy_next = 1'b1;
              scan_pend_next = 1'b0;
              state_next     = S_SCAN;
            end
            MODE_READ: begin
              if (req_in_range) begin
                fac_rd_en   = 1'b1;
                fac_rd_addr = IDX_W'(req.facet);
                state_next  = S_READ;
              end else begin
                rsp_valid_next  = 1'b1;
                rsp_status_next = 1'b1;
              end
            end
            default: begin
              rsp_valid_next = 1'b1;
            end
          endcase
        end
      end

      // present the read record once the output register is free
      S_READ: begin
        if (slot_free) begin
          rsp_valid_next  = 1'b1;
          rsp_dist_next   = fac_rd_data.dist_val;
          rsp_mem_next    = fac_rd_data.member;
          rsp_status_next = 1'b0;
          state_next      = S_IDLE;
        end
      end

      // queue every member seed, one facet read per cycle
      S_SCAN: begin
        if (scan_busy) begin
          fac_rd_en      = 1'b1;
          fac_rd_addr    = scan_addr;
          scan_prev_next = scan_addr;
          scan_pend_next = 1'b1;
          if (scan_addr == IDX_LAST) begin
            scan_busy_next = 1'b0;
          end else begin
            scan_addr_next = scan_addr + 1'b1;
          end
        end else begin
          scan_pend_next = 1'b0;
        end
        if (scan_pend && fac_rd_data.member && fac_rd_data.dist_val == '0 &&
            tail < PTR_FULL) begin
          q_wr_en   = 1'b1;
          q_wr_addr = tail[IDX_W-1:0];
          q_wr_data = scan_prev;
          tail_next = tail + 1'b1;
        end
        if (!scan_busy && !scan_pend) begin
          state_next = S_POP;
        end
      end

      // take the next queued facet or end the run
      S_POP: begin
        if (head == tail) begin
          head_next       = '0;
          tail_next       = '0;
          reply_pend_next = 1'b1;
          state_next      = S_IDLE;
        end else begin
          q_rd_en    = 1'b1;
          q_rd_addr  = head[IDX_W-1:0];
          head_next  = head + 1'b1;
          state_next = S_CUR;
        end
      end

      // fetch the dequeued facet's record and neighbours
      S_CUR: begin
        fac_rd_en   = 1'b1;
        nbr_rd_en   = 1'b1;
        fac_rd_addr = q_rd_data;
        state_next  = S_FETCH;
      end

      S_FETCH: begin
        d_next        = fac_rd_data.dist_val;
        nbrs_next     = nbr_rd_data;
        edge_idx_next = '0;
        state_next    = S_EDGE;
      end

      // look up the neighbour across the current edge
      S_EDGE: begin
        if (nb_present) begin
          fac_rd_en   = 1'b1;
          fac_rd_addr = IDX_W'(nb_sel);
          nb_reg_next = IDX_W'(nb_sel);
          state_next  = S_CHECK;
        end else if (edge_idx == EDGE_LAST) begin
          state_next = S_POP;
        end else begin
          edge_idx_next = edge_idx + 1'b1;
        end
      end

      // relax the neighbour and queue it when lowered and the queue has room
      S_CHECK: begin
        if (fac_rd_data.member && d != DIST_MAX && (d + 1'b1) < fac_rd_data.dist_val) begin
          fac_wr_en   = 1'b1;
          fac_wr_addr = nb_reg;
          fac_wr_data = '{member: 1'b1, dist_val: d + 1'b1};
          if (tail < PTR_FULL) begin
            q_wr_en   = 1'b1;
            q_wr_addr = tail[IDX_W-1:0];
            q_wr_data = nb_reg;
            tail_next = tail + 1'b1;
          end
        end
        if (edge_idx == EDGE_LAST) begin
          state_next = S_POP;
        end else begin
          edge_idx_next = edge_idx + 1'b1;
          state_next    = S_EDGE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      reply_pend <= 1'b0;
      clr_addr   <= '0;
      scan_busy  <= 1'b0;
      scan_pend  <= 1'b0;
      head       <= '0;
      tail       <= '0;
      edge_idx   <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      reply_pend <= reply_pend_next;
      clr_addr   <= clr_addr_next;
      scan_busy  <= scan_busy_next;
      scan_pend  <= scan_pend_next;
      head       <= head_next;
      tail       <= tail_next;
      edge_idx   <= edge_idx_next;
      rsp_valid  <= rsp_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_addr  <= scan_addr_next;
    scan_prev  <= scan_prev_next;
    d          <= d_next;
    nbrs       <= nbrs_next;
    nb_reg     <= nb_reg_next;
    rsp_dist   <= rsp_dist_next;
    rsp_mem    <= rsp_mem_next;
    rsp_status <= rsp_status_next;
  end

  // membership and distance per facet
  mfbd_ram #(
    .WIDTH ($bits(facet_rec_t)),
    .DEPTH (MAX_FACETS)
  ) u_facet_ram (
    .clk     (clk),
    .wr_en   (fac_wr_en),
    .wr_addr (fac_wr_addr),
    .wr_data (fac_wr_data),
    .rd_en   (fac_rd_en),
    .rd_addr (fac_rd_addr),
    .rd_data (fac_rd_data)
  );

  // adjacency per facet
  mfbd_ram #(
    .WIDTH ($bits(nbr_rec_t)),
    .DEPTH (MAX_FACETS)
  ) u_nbr_ram (
    .clk     (clk),
    .wr_en   (nbr_wr_en),
    .wr_addr (fac_wr_addr),
    .wr_data (nbr_wr_data),
    .rd_en   (nbr_rd_en),
    .rd_addr (fac_rd_addr),
    .rd_data (nbr_rd_data)
  );

  // fifo work queue
  mfbd_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_FACETS)
  ) u_queue_ram (
    .clk     (clk),
    .wr_en   (q_wr_en),
    .wr_addr (q_wr_addr),
    .wr_data (q_wr_data),
    .rd_en   (q_rd_en),
    .rd_addr (q_rd_addr),
    .rd_data (q_rd_data)
  );

  // checks
  a_head_behind_tail: assert property (@(posedge clk) disable iff (rst)
    head <= tail)
    else $error("queue head passed tail");

  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    tail <= PTR_FULL)
    else $error("queue tail beyond capacity");

  a_no_take_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !(req.valid && req.ready))
    else $error("transaction taken during clearing pass");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    !(fac_wr_en && fac_rd_en && fac_wr_addr == fac_rd_addr))
    else $error("facet ram read and write at the same address");

  a_relax_lowers: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && fac_wr_en) |-> fac_wr_data.dist_val < fac_rd_data.dist_val)
    else $error("relaxation did not lower the distance");

endmodule

// ===== test/tb_mesh_facet_bfs_distance.sv =====
// self-checking testbench for the facet distance block: mesh patches, runs and reads
`timescale 1ns / 1ps

module tb_mesh_facet_bfs_distance;
  import mfbd_pkg::*;

  localparam int unsigned NFACETS     = MAX_FACETS_DEF;
  localparam int unsigned NO_NEIGHBOR = NFACETS;
  localparam int unsigned NB_ALL_ONES = (1 << NBR_W) - 1;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned QUIET_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [FACET_W-1:0] facet;
    logic               member;
    logic [DIST_W-1:0]  start_distance;
    logic [NBR_W-1:0]   nb_a;
    logic [NBR_W-1:0]   nb_b;
    logic [NBR_W-1:0]   nb_c;
  } facet_request_t;

  typedef struct packed {
    logic [DIST_W-1:0] facet_distance;
    logic              is_member;
    logic              status;
  } facet_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mfbd_req_if req_ch ();
  mfbd_rsp_if rsp_ch ();

  mesh_facet_bfs_distance DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // own copy of the mesh tables
  logic              mesh_member [0:NFACETS-1];
  logic [DIST_W-1:0] mesh_dist   [0:NFACETS-1];
  logic [NBR_W-1:0]  mesh_nbr    [0:NFACETS-1][0:EDGES-1];
  int unsigned       bfs_fifo    [0:NFACETS-1];

  facet_request_t requests_waiting[$];
  facet_reply_t   replies_due[$];
  facet_request_t staged;
  facet_request_t taken;
  facet_reply_t   seen;
  facet_reply_t   due;

  bit          ever_loaded [0:NFACETS-1];
  int unsigned loaded_list[$];

  bit          req_busy = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  // clock
  always #4 clk = ~clk;

  // apply one transaction to the mesh tables and give its reply
  function automatic facet_reply_t apply_to_mesh(input facet_request_t rq);
    facet_reply_t rp;
    int unsigned  head;
    int unsigned  tail;
    int unsigned  cur;
    int unsigned  nb;
    int unsigned  d;
    rp = '0;
    if (rq.mode == MODE_LOAD) begin
      if (rq.facet < NFACETS) begin
        mesh_member[rq.facet] = rq.member;
        mesh_dist[rq.facet] = rq.start_distance;
        mesh_nbr[rq.facet][0] = rq.nb_a;
        mesh_nbr[rq.facet][1] = rq.nb_b;
        mesh_nbr[rq.facet][2] = rq.nb_c;
      end else begin
        rp.status = 1'b1;
      end
    end else if (rq.mode == MODE_RUN) begin
      // seeds in ascending facet order
      tail = 0;
      for (int f = 0; f < NFACETS; f++) begin
        if (mesh_member[f] && mesh_dist[f] == '0 && tail < NFACETS) begin
          bfs_fifo[tail] = f;
          tail++;
        end
      end
      // fifo relaxation across every edge of the facet
      head = 0;
      while (head < tail) begin
        cur = bfs_fifo[head];
        head++;
        d = mesh_dist[cur];
        for (int e = 0; e < EDGES; e++) begin
          nb = mesh_nbr[cur][e];
          if (nb < NFACETS && mesh_member[nb] && d < DIST_MAX && d + 1 < mesh_dist[nb]) begin
            mesh_dist[nb] = DIST_W'(d + 1);
            if (tail < NFACETS) begin
              bfs_fifo[tail] = nb;
              tail++;
            end
          end
        end
      end
    end else if (rq.mode == MODE_READ) begin
      if (rq.facet < NFACETS) begin
        rp.facet_distance = mesh_dist[rq.facet];
        rp.is_member = mesh_member[rq.facet];
      end else begin
        rp.status = 1'b1;
      end
    end
    return rp;
  endfunction

  // queue one transaction for the driver
  task automatic push_item(input logic [MODE_W-1:0] mode, input int unsigned facet,
                           input int unsigned member, input int unsigned start_dist,
                           input int unsigned a, input int unsigned b, input int unsigned c);
    facet_request_t it;
    it.mode = mode;
    it.facet = FACET_W'(facet);
    it.member = member[0];
    it.start_distance = DIST_W'(start_dist);
    it.nb_a = NBR_W'(a);
    it.nb_b = NBR_W'(b);
    it.nb_c = NBR_W'(c);
    if (mode == MODE_LOAD && !ever_loaded[it.facet]) begin
      ever_loaded[it.facet] = 1'b1;
      loaded_list = {loaded_list, 32'(it.facet)};
    end
    requests_waiting = {requests_waiting, it};
  endtask

  function automatic int unsigned some_loaded();
    return loaded_list[$urandom_range(loaded_list.size() - 1)];
  endfunction

  // neighbour value: any 11-bit code, none, or a facet already loaded
  function automatic int unsigned any_neighbor();
    int unsigned pick;
    pick = $urandom_range(3);
    if (pick < 2) return $urandom_range(NB_ALL_ONES);
    else if (pick == 2) return NO_NEIGHBOR;
    else return some_loaded();
  endfunction

  // sender pauses until every reply is back
  task automatic wait_until_settled();
    while (requests_waiting.size() != 0 || req_busy || replies_due.size() != 0)
      @(posedge clk);
  endtask

  // one phase of random mesh patches mixed with noise
  task automatic random_phase(input int unsigned n_items, input int unsigned send_pct,
                              input int unsigned recv_pct, input bit with_hold);
    int unsigned      len;
    int unsigned      base;
    int unsigned      seed_a;
    int unsigned      seed_b;
    int unsigned      rot;
    int unsigned      k;
    int unsigned      pick;
    int unsigned      f;
    int unsigned      m;
    int unsigned      d;
    int unsigned      slot [0:2];
    bit               held;
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
    held = 1'b0;
    k = 0;
    while (k < n_items) begin
      if ($urandom_range(3) == 0) begin
        // short burst of noise
        for (int j = 0; j < $urandom_range(1, 4); j++) begin
          pick = $urandom_range(9);
          if (pick <= 3) begin
            push_item(MODE_LOAD, $urandom_range(NFACETS - 1), $urandom_range(1),
                      $urandom_range(16'hffff), any_neighbor(), any_neighbor(),
                      any_neighbor());
          end else if (pick <= 5) begin
            push_item(MODE_READ, some_loaded(), $urandom_range(1), $urandom_range(16'hffff),
                      $urandom_range(NB_ALL_ONES), 0, 0);
          end else if (pick == 6) begin
            push_item(MODE_UNUSED, $urandom_range(NFACETS - 1), $urandom_range(1),
                      $urandom_range(16'hffff), $urandom_range(NB_ALL_ONES),
                      $urandom_range(NB_ALL_ONES), $urandom_range(NB_ALL_ONES));
          end else if (pick == 7) begin
            push_item(MODE_RUN, $urandom_range(NFACETS - 1), $urandom_range(1),
                      $urandom_range(16'hffff), $urandom_range(NB_ALL_ONES),
                      $urandom_range(NB_ALL_ONES), $urandom_range(NB_ALL_ONES));
          end else begin
            f = $urandom_range(NFACETS - 1);
            push_item(MODE_LOAD, f, $urandom_range(1), $urandom_range(16'hffff),
                      any_neighbor(), any_neighbor(), any_neighbor());
            push_item(MODE_READ, f, 0, 0, 0, 0, 0);
          end
          k++;
        end
      end else begin
        // triangle strip with one or two seeds and an optional cross link per facet
        len = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
        base = $urandom_range(NFACETS - len);
        seed_a = $urandom_range(len - 1);
        seed_b = ($urandom_range(2) == 0) ? $urandom_range(len - 1) : seed_a;
        for (int i = 0; i < len; i++) begin
          slot[0] = (i > 0) ? base + i - 1 : NO_NEIGHBOR;
          slot[1] = (i < len - 1) ? base + i + 1 : NO_NEIGHBOR;
          pick = $urandom_range(5);
          if (pick < 2) slot[2] = NO_NEIGHBOR;
          else if (pick < 4) slot[2] = base + $urandom_range(len - 1);
          else if (pick == 4) slot[2] = $urandom_range(NFACETS + 1, NB_ALL_ONES);
          else slot[2] = some_loaded();
          if (i == seed_a || i == seed_b) begin
            m = 1;
            d = 0;
          end else begin
            m = ($urandom_range(9) != 0);
            pick = $urandom_range(9);
            if (pick < 7) d = DIST_MAX;
            else if (pick < 9) d = $urandom_range(1, 16'hffff);
            else d = $urandom_range(1, 3);
          end
          rot = $urandom_range(2);
          push_item(MODE_LOAD, base + i, m, d, slot[rot], slot[(rot + 1) % 3],
                    slot[(rot + 2) % 3]);
        end
        push_item(MODE_RUN, $urandom_range(NFACETS - 1), $urandom_range(1),
                  $urandom_range(16'hffff), $urandom_range(NB_ALL_ONES),
                  $urandom_range(NB_ALL_ONES), $urandom_range(NB_ALL_ONES));
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(4) != 0) push_item(MODE_READ, base + i, 0, 0, 0, 0, 0);
        end
        k += 2 * len + 1;
        // long receiver hold-off while reads are still queued
        if (with_hold && !held && k >= n_items / 3) begin
          hold_requests++;
          held = 1'b1;
        end
        if ($urandom_range(3) == 0) wait_until_settled();
      end
    end
    wait_until_settled();
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_busy) begin
      if (requests_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        staged = requests_waiting.pop_front();
        req_ch.mode <= staged.mode;
        req_ch.facet <= staged.facet;
        req_ch.member <= staged.member;
        req_ch.start_distance <= staged.start_distance;
        req_ch.neighbor_a <= staged.nb_a;
        req_ch.neighbor_b <= staged.nb_b;
        req_ch.neighbor_c <= staged.nb_c;
        req_ch.valid <= 1'b1;
        req_busy <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // reply ready, with random stalls and the long hold-off
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = LONG_HOLD - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // accepted request transaction: predict its reply
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      taken.mode = req_ch.mode;
      taken.facet = req_ch.facet;
      taken.member = req_ch.member;
      taken.start_distance = req_ch.start_distance;
      taken.nb_a = req_ch.neighbor_a;
      taken.nb_b = req_ch.neighbor_b;
      taken.nb_c = req_ch.neighbor_c;
      replies_due = {replies_due, apply_to_mesh(taken)};
      req_busy <= 1'b0;
    end
  end

  // accepted reply transaction: compare with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      seen.facet_distance = rsp_ch.facet_distance;
      seen.is_member = rsp_ch.is_member;
      seen.status = rsp_ch.status;
      if (replies_due.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected reply: dist %0d member %b status %b",
                   seen.facet_distance, seen.is_member, seen.status);
        fail_count++;
      end else begin
        due = replies_due.pop_front();
        if (seen.facet_distance !== due.facet_distance || seen.is_member !== due.is_member ||
            seen.status !== due.status) begin
          if (fail_count < 10)
            $display("reply mismatch: expected dist %0d member %b status %b, got %0d %b %b",
                     due.facet_distance, due.is_member, due.status,
                     seen.facet_distance, seen.is_member, seen.status);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("mesh_facet_bfs_distance test failed");
      $finish;
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.mode = '0;
    req_ch.facet = '0;
    req_ch.member = 1'b0;
    req_ch.start_distance = '0;
    req_ch.neighbor_a = '0;
    req_ch.neighbor_b = '0;
    req_ch.neighbor_c = '0;
    rsp_ch.ready = 1'b0;
    for (int f = 0; f < NFACETS; f++) begin
      mesh_member[f] = 1'b0;
      mesh_dist[f] = '0;
      for (int e = 0; e < EDGES; e++) mesh_nbr[f][e] = '0;
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: seeds, saturated and blocked facets, non-member zero, all-ones fields
    push_item(MODE_LOAD, 0, 1, 0, 1, NO_NEIGHBOR, 5);
    push_item(MODE_LOAD, 1, 1, 16'hfffe, 0, NFACETS - 1, NO_NEIGHBOR);
    push_item(MODE_LOAD, NFACETS - 1, 1, DIST_MAX, NFACETS - 1, 0, NO_NEIGHBOR);
    push_item(MODE_LOAD, 2, 0, 0, 0, 1, 3);
    push_item(MODE_LOAD, 3, 1, DIST_MAX, 2, NO_NEIGHBOR, NO_NEIGHBOR);
    push_item(MODE_LOAD, 4, 1, 0, NB_ALL_ONES, NB_ALL_ONES, NB_ALL_ONES);
    push_item(MODE_LOAD, 5, 1, 1, 6, NO_NEIGHBOR, NO_NEIGHBOR);
    push_item(MODE_LOAD, 6, 1, DIST_MAX, 5, NO_NEIGHBOR, NO_NEIGHBOR);
    push_item(MODE_RUN, NFACETS - 1, 1, DIST_MAX, NB_ALL_ONES, NB_ALL_ONES, NB_ALL_ONES);
    for (int f = 0; f < 7; f++) push_item(MODE_READ, f, 0, 0, 0, 0, 0);
    push_item(MODE_READ, NFACETS - 1, 1, DIST_MAX, NB_ALL_ONES, NB_ALL_ONES, NB_ALL_ONES);
    push_item(MODE_UNUSED, NFACETS - 1, 1, DIST_MAX, NB_ALL_ONES, NB_ALL_ONES, NB_ALL_ONES);
    push_item(MODE_UNUSED, 0, 0, 0, 0, 0, 0);
    // reload a facet as a second seed and run again
    push_item(MODE_LOAD, 6, 1, 0, 5, NO_NEIGHBOR, NO_NEIGHBOR);
    push_item(MODE_RUN, 0, 0, 0, 0, 0, 0);
    push_item(MODE_READ, 5, 0, 0, 0, 0, 0);
    push_item(MODE_READ, 6, 0, 0, 0, 0, 0);
    push_item(MODE_READ, NFACETS - 1, 0, 0, 0, 0, 0);
    wait_until_settled();

    // random phases with different idling
    random_phase(95, 0, 0, 1'b1);
    random_phase(95, 62, 0, 1'b0);
    random_phase(95, 0, 62, 1'b0);
    random_phase(95, 27, 27, 1'b0);

    wait_until_settled();
    repeat (QUIET_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("mesh_facet_bfs_distance test passed");
    end else begin
      $display("mesh_facet_bfs_distance test failed");
    end
    $finish;
  end

endmodule
